// File: rtl/core/dcmct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmct_pkg
// Widths, reset values, codes and shared types of the master clock drift
// tracker.
// ----------------------------------------------------------------------------
package dcmct_pkg;

	localparam int TIME_W     = 64;
	localparam int REF_W      = 32;
	localparam int CYC_W      = 30;
	localparam int LIM_W      = 20;
	localparam int ADJ_W      = 21;
	localparam int SUM_W      = 48;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 30;

	// The window length must be a power of two.
	localparam int WINDOW_TICKS = 1024;
	localparam int WIN_SHIFT    = $clog2(WINDOW_TICKS);
	localparam int CNT_W        = $clog2(WINDOW_TICKS);
	localparam int AVG_W        = SUM_W - WIN_SHIFT + 3;

	localparam int MOD_STEPS = REF_W;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	localparam logic [CYC_W-1:0] CYCLE_RESET = CYC_W'(1000000);
	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CYCLE_LENGTH = 1'b0,
		REG_ADJUST_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CALC,
		ST_START,
		ST_MOD,
		ST_ACCUM,
		ST_WIN1,
		ST_WIN2,
		ST_WIN3,
		ST_BASE,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             start;
		logic [REF_W-1:0] dividend;
		logic [CYC_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [CYC_W-1:0] rem;
	} mod_rsp_t;

endpackage

// File: rtl/core/dcmct_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmct_if
// Valid/ready channels that carry tick beats into the tracker and result
// beats out of it.
// ----------------------------------------------------------------------------
interface dcmct_in_if;
	logic                         valid;
	logic                         ready;
	logic [dcmct_pkg::TIME_W-1:0] monotonic_time_ns;
	logic [dcmct_pkg::REF_W-1:0]  ref_clock_time;

	modport source (output valid, output monotonic_time_ns, output ref_clock_time,
		input ready);
	modport sink (input valid, input monotonic_time_ns, input ref_clock_time,
		output ready);
endinterface

interface dcmct_out_if;
	logic                                valid;
	logic                                ready;
	logic        [dcmct_pkg::TIME_W-1:0] application_time_ns;
	logic signed [dcmct_pkg::REF_W-1:0]  normalized_diff_ns;
	logic signed [dcmct_pkg::ADJ_W-1:0]  current_adjust_ns;
	logic                                tracking_started;

	modport source (output valid, output application_time_ns, output normalized_diff_ns,
		output current_adjust_ns, output tracking_started, input ready);
	modport sink (input valid, input application_time_ns, input normalized_diff_ns,
		input current_adjust_ns, input tracking_started, output ready);
endinterface

// File: rtl/core/dcmct_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmct_mod_unit
// Serial restoring remainder unit: one dividend bit per cycle, the remainder
// is presented with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module dcmct_mod_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  dcmct_pkg::mod_req_t req,
	output dcmct_pkg::mod_rsp_t rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [dcmct_pkg::MOD_CNT_W-1:0] cnt_q;
	logic [dcmct_pkg::REF_W-1:0]     quo_q;
	logic [dcmct_pkg::CYC_W-1:0]     div_q;
	logic [dcmct_pkg::CYC_W-1:0]     rem_q;
	logic [dcmct_pkg::CYC_W:0]       shifted;
	logic [dcmct_pkg::CYC_W:0]       trial;
	logic [dcmct_pkg::CYC_W-1:0]     rem_next;

	always_comb begin
		shifted  = {rem_q, quo_q[dcmct_pkg::REF_W-1]};
		trial    = shifted - {1'b0, div_q};
		rem_next = trial[dcmct_pkg::CYC_W] ? shifted[dcmct_pkg::CYC_W-1:0]
			: trial[dcmct_pkg::CYC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= dcmct_pkg::MOD_CNT_W'(dcmct_pkg::MOD_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[dcmct_pkg::REF_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// File: rtl/core/dc_master_clock_drift_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dc_master_clock_drift_tracker
// Keeps the master application time locked to the reference slave clock by
// accumulating a drift adjustment into a time base, one tick per bus cycle.
// ----------------------------------------------------------------------------
// Each ingress beat carries the raw monotonic time and the reference clock
// time of one bus cycle. The block answers with one egress beat holding the
// application time, the normalized difference, the adjustment after the
// tick and the tracking flag. Configuration writes (cycle length, adjustment
// limit) are taken at any clock edge with cfg_we high and are meant to be
// issued only while no tick is in flight.
// The remainder step runs in the serial remainder unit, which retires one
// dividend bit per cycle; a window end adds the average and clamp states
// (ST_WIN1 to ST_WIN3). One tick is in work at a time: ingress is ready
// only while the sequencer is idle, so a new tick is not accepted before
// the previous one has been loaded into the output register.
// The egress beat sits in an output register; a new tick is accepted while
// it waits, and the finished tick then holds until the receiver takes the
// earlier beat. Reset clears all tracking state and loads the default
// cycle length of 1 ms and adjustment limit of 1000 ns.
// ----------------------------------------------------------------------------
module dc_master_clock_drift_tracker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dcmct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcmct_pkg::CFG_DATA_W-1:0] cfg_data,
	dcmct_in_if.sink                         ingress,
	dcmct_out_if.source                      egress
);

	localparam int TW = dcmct_pkg::TIME_W;
	localparam int RW = dcmct_pkg::REF_W;
	localparam int SW = dcmct_pkg::SUM_W;
	localparam int AW = dcmct_pkg::AVG_W;
	localparam int JW = dcmct_pkg::ADJ_W;

	dcmct_pkg::state_t state_q, state_d;
	dcmct_pkg::mod_req_t mod_req;
	dcmct_pkg::mod_rsp_t mod_rsp;

	logic [dcmct_pkg::CYC_W-1:0] cyc_len_q;
	logic [dcmct_pkg::LIM_W-1:0] adj_lim_q;

	logic [TW-1:0]              time_base_q;
	logic [RW-1:0]              last_app_low_q;
	logic [RW-1:0]              last_raw_diff_q;
	logic [SW-1:0]              diff_sum_q;
	logic [SW-1:0]              drift_sum_q;
	logic [dcmct_pkg::CNT_W-1:0] win_cnt_q;
	logic signed [JW-1:0]       adjust_q;
	logic                       started_q;

	logic [TW-1:0]               raw_q;
	logic [RW-1:0]               ref_q;
	logic [TW-1:0]               app_q;
	logic [RW-1:0]               diff_q;
	logic [RW-1:0]               drift_q;
	logic [dcmct_pkg::CYC_W-1:0] cyc_eff_q;
	logic [RW-1:0]               norm_q;
	logic signed [SW:0]          dsum_q;
	logic signed [AW-1:0]        avg_q;
	logic signed [1:0]           fsgn_q;

	logic                  out_valid_q;
	logic [TW-1:0]         out_app_q;
	logic [RW-1:0]         out_norm_q;
	logic signed [JW-1:0]  out_adj_q;
	logic                  out_started_q;

	logic                  accept;
	logic                  load_out;
	logic [TW:0]           base_sub;
	logic [TW-1:0]         app_c;
	logic [RW-1:0]         diff_c;
	logic [dcmct_pkg::CYC_W-1:0] cyc_eff_c;
	logic [RW-1:0]         half_w;
	logic [dcmct_pkg::CNT_W:0] cnt_next;
	logic                  win_end;
	logic signed [SW-1:0]  fsum;
	logic signed [SW:0]    dsum_round;
	logic signed [AW-1:0]  avg_c;
	logic signed [AW-1:0]  lim_s;
	logic signed [AW-1:0]  adj_sum;
	logic signed [JW-1:0]  adj_clamped;
	logic signed [1:0]     nsgn;
	logic signed [JW:0]    base_step;

	// Control outputs of the sequencer.
	always_comb begin
		ingress.ready = (state_q == dcmct_pkg::ST_IDLE);
		mod_req.start = (state_q == dcmct_pkg::ST_START);
		load_out      = (state_q == dcmct_pkg::ST_FIN) && (!out_valid_q || egress.ready);
	end

	assign accept = ingress.valid && ingress.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dcmct_pkg::ST_IDLE:  if (accept) state_d = dcmct_pkg::ST_CALC;
			dcmct_pkg::ST_CALC:  state_d = dcmct_pkg::ST_START;
			dcmct_pkg::ST_START: state_d = dcmct_pkg::ST_MOD;
			dcmct_pkg::ST_MOD:   if (mod_rsp.done) state_d = dcmct_pkg::ST_ACCUM;
			dcmct_pkg::ST_ACCUM: begin
				if (!started_q) state_d = dcmct_pkg::ST_FIN;
				else if (win_end) state_d = dcmct_pkg::ST_WIN1;
				else state_d = dcmct_pkg::ST_BASE;
			end
			dcmct_pkg::ST_WIN1:  state_d = dcmct_pkg::ST_WIN2;
			dcmct_pkg::ST_WIN2:  state_d = dcmct_pkg::ST_WIN3;
			dcmct_pkg::ST_WIN3:  state_d = dcmct_pkg::ST_BASE;
			dcmct_pkg::ST_BASE:  state_d = dcmct_pkg::ST_FIN;
			dcmct_pkg::ST_FIN:   if (load_out) state_d = dcmct_pkg::ST_IDLE;
			default:             state_d = dcmct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		base_sub  = {1'b0, raw_q} - {1'b0, time_base_q};
		app_c     = (base_sub[TW] && !time_base_q[TW-1]) ? raw_q : base_sub[TW-1:0];
		diff_c    = last_app_low_q - ref_q;
		cyc_eff_c = (cyc_len_q == '0) ? dcmct_pkg::CYC_W'(1) : cyc_len_q;
		half_w    = RW'(cyc_eff_q >> 1);

		mod_req.dividend = diff_q + half_w;
		mod_req.divisor  = cyc_eff_q;

		cnt_next = {1'b0, win_cnt_q} + 1'b1;
		win_end  = cnt_next >= (dcmct_pkg::CNT_W + 1)'(dcmct_pkg::WINDOW_TICKS);

		fsum       = $signed(diff_sum_q);
		dsum_round = $signed({drift_sum_q[SW-1], drift_sum_q})
			+ (SW + 1)'(dcmct_pkg::WINDOW_TICKS / 2);
		// Signed division by the window length, truncated toward zero.
		avg_c = AW'(dsum_q >>> dcmct_pkg::WIN_SHIFT)
			+ AW'((dsum_q[SW] && (dsum_q[dcmct_pkg::WIN_SHIFT-1:0] != '0)) ? 1 : 0);

		lim_s   = $signed({{(AW - dcmct_pkg::LIM_W){1'b0}}, adj_lim_q});
		adj_sum = AW'(adjust_q) + avg_q + AW'(fsgn_q);
		if (adj_sum < -lim_s) adj_clamped = JW'(-lim_s);
		else if (adj_sum > lim_s) adj_clamped = JW'(lim_s);
		else adj_clamped = JW'(adj_sum);

		nsgn      = norm_q[RW-1] ? -2'sd1 : ((norm_q != '0) ? 2'sd1 : 2'sd0);
		base_step = (JW + 1)'(adjust_q) + (JW + 1)'(nsgn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= dcmct_pkg::ST_IDLE;
			cyc_len_q       <= dcmct_pkg::CYCLE_RESET;
			adj_lim_q       <= dcmct_pkg::LIMIT_RESET;
			time_base_q     <= '0;
			last_app_low_q  <= '0;
			last_raw_diff_q <= '0;
			diff_sum_q      <= '0;
			drift_sum_q     <= '0;
			win_cnt_q       <= '0;
			adjust_q        <= '0;
			started_q       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (dcmct_pkg::cfg_reg_t'(cfg_index))
					dcmct_pkg::REG_CYCLE_LENGTH: cyc_len_q <= cfg_data;
					dcmct_pkg::REG_ADJUST_LIMIT: adj_lim_q <= cfg_data[dcmct_pkg::LIM_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				dcmct_pkg::ST_CALC: begin
					last_app_low_q  <= app_c[RW-1:0];
					last_raw_diff_q <= diff_c;
				end
				dcmct_pkg::ST_ACCUM: begin
					if (started_q) begin
						diff_sum_q  <= diff_sum_q + {{(SW - RW){norm_q[RW-1]}}, norm_q};
						drift_sum_q <= drift_sum_q + {{(SW - RW){drift_q[RW-1]}}, drift_q};
						if (!win_end) win_cnt_q <= cnt_next[dcmct_pkg::CNT_W-1:0];
					end else begin
						started_q <= (norm_q != '0);
					end
				end
				dcmct_pkg::ST_WIN3: begin
					adjust_q    <= adj_clamped;
					diff_sum_q  <= '0;
					drift_sum_q <= '0;
					win_cnt_q   <= '0;
				end
				dcmct_pkg::ST_BASE: begin
					time_base_q <= time_base_q + TW'(base_step);
				end
				default: ;
			endcase
			if (load_out) out_valid_q <= 1'b1;
			else if (egress.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q <= ingress.monotonic_time_ns;
			ref_q <= ingress.ref_clock_time;
		end
		if (state_q == dcmct_pkg::ST_CALC) begin
			app_q     <= app_c;
			diff_q    <= diff_c;
			drift_q   <= diff_c - last_raw_diff_q;
			cyc_eff_q <= cyc_eff_c;
		end
		if (state_q == dcmct_pkg::ST_MOD && mod_rsp.done) begin
			norm_q <= RW'(mod_rsp.rem) - half_w;
		end
		if (state_q == dcmct_pkg::ST_WIN1) begin
			dsum_q <= dsum_round;
			if (fsum >= SW'(dcmct_pkg::WINDOW_TICKS)) fsgn_q <= 2'sd1;
			else if (fsum <= -SW'(dcmct_pkg::WINDOW_TICKS)) fsgn_q <= -2'sd1;
			else fsgn_q <= 2'sd0;
		end
		if (state_q == dcmct_pkg::ST_WIN2) begin
			avg_q <= avg_c;
		end
		if (load_out) begin
			out_app_q     <= app_q;
			out_norm_q    <= norm_q;
			out_adj_q     <= adjust_q;
			out_started_q <= started_q;
		end
	end

	dcmct_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	assign egress.valid               = out_valid_q;
	assign egress.application_time_ns = out_app_q;
	assign egress.normalized_diff_ns  = $signed(out_norm_q);
	assign egress.current_adjust_ns   = out_adj_q;
	assign egress.tracking_started    = out_started_q;

endmodule

// File: rtl/core/dcmct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmct_checker
// Port-level checks of the drift tracker, bound to the top level.
// ----------------------------------------------------------------------------
module dcmct_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [dcmct_pkg::TIME_W-1:0] app_time,
	input logic                         started
);

	logic       in_beat;
	logic       out_beat;
	logic [1:0] pending_q;
	logic       seen_started_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q      <= '0;
			seen_started_q <= 1'b0;
		end else begin
			pending_q <= pending_q + {1'b0, in_beat} - {1'b0, out_beat};
			if (out_beat && started) seen_started_q <= 1'b1;
		end
	end

	// One tick is worked on at a time.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("ingress ready right after an accepted beat");

	// Every result beat belongs to an accepted tick.
	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != 2'd0))
		else $error("result beat without an outstanding tick");

	// Tracking, once reported, stays on.
	a_tracking_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && seen_started_q) |-> started)
		else $error("tracking flag dropped after it was reported");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(app_time)))
		else $error("stalled result beat changed or vanished");

endmodule

bind dc_master_clock_drift_tracker dcmct_checker u_dcmct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (ingress.valid),
	.in_ready  (ingress.ready),
	.out_valid (egress.valid),
	.out_ready (egress.ready),
	.app_time  (egress.application_time_ns),
	.started   (egress.tracking_started)
);
